FILE: rtl/gces_pkg.sv
// ----------------------------------------------------------------------------
// gces_pkg
// Types and constants shared by the grid cell elevation statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package gces_pkg;

    localparam int MUL_W  = 33;
    localparam int DIV_W  = 49;
    localparam int DVS_W  = 17;
    localparam int STEP_W = 6;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic        [15:0] count;
        logic signed [31:0] hmin;
        logic signed [31:0] hmax;
        logic signed [31:0] mean;
        logic        [63:0] dev;
    } cell_row_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL_MEAN,
        ST_DIV,
        ST_MUL_DEV,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/gces_in_if.sv
// ----------------------------------------------------------------------------
// gces_in_if
// Input channel: one word per point or read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gces_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic        [11:0] cell_index;
    logic signed [31:0] height;

    modport source (output valid, func, cell_index, height, input ready);
    modport sink   (input valid, func, cell_index, height, output ready);
endinterface

`default_nettype wire

FILE: rtl/gces_out_if.sv
// ----------------------------------------------------------------------------
// gces_out_if
// Output channel: one word of cell statistics per input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gces_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] point_count;
    logic signed [31:0] height_min;
    logic signed [31:0] height_max;
    logic signed [31:0] height_mean;
    logic        [63:0] deviation_sum;
    logic               count_saturated;

    modport source (output valid, point_count, height_min, height_max, height_mean,
                    deviation_sum, count_saturated, input ready);
    modport sink   (input valid, point_count, height_min, height_max, height_mean,
                    deviation_sum, count_saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/gces_serial_mul.sv
// ----------------------------------------------------------------------------
// gces_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gces_serial_mul
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [gces_pkg::MUL_W-1:0]       a,
    input  wire logic [gces_pkg::MUL_W-1:0]       b,
    output logic                                  done,
    output logic      [2*gces_pkg::MUL_W-1:0]     product
);

    localparam int W = gces_pkg::MUL_W;

    logic [2*W-1:0]              acc_reg, acc_next;
    logic [W-1:0]                a_reg, a_next;
    logic [gces_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [W:0]                  part;

    always_comb
    begin
        part      = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = {{W{1'b0}}, b};
            a_next   = a;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = {part, acc_reg[W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gces_pkg::STEP_W'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/gces_serial_div.sv
// ----------------------------------------------------------------------------
// gces_serial_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gces_serial_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gces_pkg::DIV_W-1:0]    dividend,
    input  wire logic [gces_pkg::DVS_W-1:0]    divisor,
    output logic                               done,
    output logic      [gces_pkg::DIV_W-1:0]    quotient
);

    localparam int W = gces_pkg::DIV_W;
    localparam int V = gces_pkg::DVS_W;

    logic [W-1:0]                q_reg, q_next;
    logic [V-1:0]                rem_reg, rem_next;
    logic [V-1:0]                dvs_reg, dvs_next;
    logic [gces_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [V:0]                  trial;
    logic [V:0]                  diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[V-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[V-1:0];
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gces_pkg::STEP_W'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: rtl/grid_cell_elevation_stats.sv
// ----------------------------------------------------------------------------
// grid_cell_elevation_stats
// Per-cell count, min, max, running mean and squared deviation sum.
// ----------------------------------------------------------------------------
// Sequence: read or out-of-range word FETCH, LOAD, DONE; first point into a
//   cell FETCH, LOAD, WRITE, DONE; occupied cell adds MUL_MEAN, DIV, MUL_DEV
//   before WRITE (multiply, divide, multiply; one serial multiplier for both).
// Throughput: one word at a time; next word taken once its result is registered.
// Reset: clearing pass over all GRID_CELLS cells of the cell memory, no input taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_elevation_stats
#(
    parameter int GRID_CELLS = 4096
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gces_in_if.sink    item_in,
    gces_out_if.source result_out
);

    localparam int ADDR_W = $clog2(GRID_CELLS);
    localparam int MW     = gces_pkg::MUL_W;
    localparam int DW     = gces_pkg::DIV_W;

    gces_pkg::cell_row_t cell_mem [GRID_CELLS];

    gces_pkg::state_t    state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                func_reg;
    logic                range_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic signed [31:0]  height_reg;
    gces_pkg::cell_row_t rd_row_reg;
    gces_pkg::cell_row_t new_row_reg;
    logic                sat_reg;
    logic                num_neg_reg;
    logic                dev_neg_reg;
    logic signed [32:0]  nm_reg;
    gces_pkg::cell_row_t out_row_reg;
    logic                out_sat_reg;
    logic                out_valid_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    gces_pkg::cell_row_t mem_wdata;
    logic                mul_start, mul_done, div_start, div_done;
    logic [MW-1:0]       mul_a, mul_b;
    logic [2*MW-1:0]     mul_prod;
    logic [DW-1:0]       div_q;
    logic [DW-1:0]       num_mag;
    logic signed [49:0]  num;
    logic signed [32:0]  m_ext, z_ext, nm, d1, d2;
    logic [MW-1:0]       m_mag, d1_mag, d2_mag;
    logic [63:0]         prod64, sum_new;
    logic [64:0]         sum_wide;
    logic                in_range, out_free;
    logic [15:0]         n;

    assign n       = rd_row_reg.count;
    assign m_ext   = {rd_row_reg.mean[31], rd_row_reg.mean};
    assign z_ext   = {height_reg[31], height_reg};
    assign m_mag   = m_ext[32] ? MW'(-m_ext) : MW'(m_ext);
    assign num     = (m_ext[32] ? -$signed({2'b00, mul_prod[47:0]})
                                :  $signed({2'b00, mul_prod[47:0]}))
                     + {{18{height_reg[31]}}, height_reg};
    assign num_mag = num[49] ? DW'(-num) : DW'(num);
    assign nm      = num_neg_reg ? -$signed(div_q[32:0]) : $signed(div_q[32:0]);
    assign d1      = z_ext - m_ext;
    assign d2      = z_ext - nm;
    assign d1_mag  = d1[32] ? MW'(-d1) : MW'(d1);
    assign d2_mag  = d2[32] ? MW'(-d2) : MW'(d2);
    assign prod64  = mul_prod[63:0];
    assign sum_wide = {1'b0, rd_row_reg.dev} + {1'b0, prod64};
    assign out_free = !out_valid_reg || result_out.ready;
    assign in_range = {20'b0, item_in.cell_index} < GRID_CELLS;

    always_comb
    begin
        if (dev_neg_reg)
            sum_new = (rd_row_reg.dev > prod64) ? rd_row_reg.dev - prod64 : 64'd0;
        else
            sum_new = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
    end

    gces_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    gces_serial_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (gces_pkg::DVS_W'(n) + 1'b1),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gces_pkg::ST_CLEAR:
                if (clr_addr_reg == ADDR_W'(GRID_CELLS - 1))
                    state_next = gces_pkg::ST_IDLE;
            gces_pkg::ST_IDLE:
                if (item_in.valid)
                    state_next = gces_pkg::ST_FETCH;
            gces_pkg::ST_FETCH:
                state_next = gces_pkg::ST_LOAD;
            gces_pkg::ST_LOAD:
                if (!range_reg || func_reg == gces_pkg::FUNC_READ)
                    state_next = gces_pkg::ST_DONE;
                else if (n == 16'd0)
                    state_next = gces_pkg::ST_WRITE;
                else
                    state_next = gces_pkg::ST_MUL_MEAN;
            gces_pkg::ST_MUL_MEAN:
                if (mul_done)
                    state_next = gces_pkg::ST_DIV;
            gces_pkg::ST_DIV:
                if (div_done)
                    state_next = gces_pkg::ST_MUL_DEV;
            gces_pkg::ST_MUL_DEV:
                if (mul_done)
                    state_next = gces_pkg::ST_WRITE;
            gces_pkg::ST_WRITE:
                state_next = gces_pkg::ST_DONE;
            gces_pkg::ST_DONE:
                if (out_free)
                    state_next = gces_pkg::ST_IDLE;
            default:
                state_next = gces_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = new_row_reg;
        mul_start = 1'b0;
        mul_a     = m_mag;
        mul_b     = MW'(n);
        div_start = 1'b0;
        case (state_reg)
            gces_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            gces_pkg::ST_LOAD:
                mul_start = range_reg && func_reg == gces_pkg::FUNC_ACCUM && n != 16'd0;
            gces_pkg::ST_MUL_MEAN:
                div_start = mul_done;
            gces_pkg::ST_DIV:
            begin
                mul_start = div_done;
                mul_a     = d1_mag;
                mul_b     = d2_mag;
            end
            gces_pkg::ST_WRITE:
                mem_we = 1'b1;
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gces_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gces_pkg::ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (state_reg == gces_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        rd_row_reg <= cell_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gces_pkg::ST_IDLE && item_in.valid)
        begin
            func_reg   <= item_in.func;
            range_reg  <= in_range;
            idx_reg    <= ADDR_W'(item_in.cell_index);
            height_reg <= item_in.height;
        end
        if (state_reg == gces_pkg::ST_LOAD)
        begin
            sat_reg <= 1'b0;
            if (!range_reg || n == 16'd0)
                new_row_reg <= (range_reg && func_reg == gces_pkg::FUNC_ACCUM)
                               ? gces_pkg::cell_row_t'{16'd1, height_reg, height_reg,
                                                       height_reg, 64'd0}
                               : gces_pkg::cell_row_t'('0);
            else
                new_row_reg <= rd_row_reg;
        end
        if (state_reg == gces_pkg::ST_MUL_MEAN && mul_done)
            num_neg_reg <= num[49];
        if (state_reg == gces_pkg::ST_DIV && div_done)
        begin
            nm_reg      <= nm;
            dev_neg_reg <= d1[32] ^ d2[32];
        end
        if (state_reg == gces_pkg::ST_MUL_DEV && mul_done)
        begin
            new_row_reg.count <= (n == gces_pkg::COUNT_MAX) ? n : n + 16'd1;
            new_row_reg.hmin  <= (height_reg < rd_row_reg.hmin) ? height_reg
                                                                : rd_row_reg.hmin;
            new_row_reg.hmax  <= (height_reg > rd_row_reg.hmax) ? height_reg
                                                                : rd_row_reg.hmax;
            new_row_reg.mean  <= nm_reg[31:0];
            new_row_reg.dev   <= sum_new;
            sat_reg           <= (n == gces_pkg::COUNT_MAX);
        end
        if (state_reg == gces_pkg::ST_DONE && out_free)
        begin
            out_row_reg <= new_row_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign item_in.ready              = (state_reg == gces_pkg::ST_IDLE);
    assign result_out.valid           = out_valid_reg;
    assign result_out.point_count     = out_row_reg.count;
    assign result_out.height_min      = out_row_reg.hmin;
    assign result_out.height_max      = out_row_reg.hmax;
    assign result_out.height_mean     = out_row_reg.mean;
    assign result_out.deviation_sum   = out_row_reg.dev;
    assign result_out.count_saturated = out_sat_reg;

endmodule

`default_nettype wire
